// File: rtl/core/mof_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mof_pkg: shared types for the move-operation folder
// Operation and feature codes, flag bit positions, and the structs that
// carry an operation, a finished feature and a push group between modules.
// ----------------------------------------------------------------------------
package mof_pkg;

    // Operation kinds; codes above MODE_MATCH are invalid and skipped
    typedef enum logic [3:0] {
        MODE_CAPLEN = 4'd0,
        MODE_CAPCHR = 4'd1,
        MODE_CAPEND = 4'd2,
        MODE_JFWD   = 4'd3,
        MODE_JBACK  = 4'd4,
        MODE_JABS   = 4'd5,
        MODE_JEND   = 4'd6,
        MODE_FFWD   = 4'd7,
        MODE_FREV   = 4'd8,
        MODE_MATCH  = 4'd9
    } mode_t;

    // Feature kinds on the result side
    typedef enum logic [2:0] {
        FT_REL_FWD  = 3'd0,
        FT_REL_BACK = 3'd1,
        FT_ABS_HEAD = 3'd2,
        FT_ABS_END  = 3'd3,
        FT_FIND_FWD = 3'd4,
        FT_FIND_REV = 3'd5
    } feature_t;

    // Bit positions inside the held flags
    localparam int FLAG_BITS     = 4;
    localparam int FLAG_FIND_BIT = 0;
    localparam int FLAG_END_BIT  = 1;
    localparam int FLAG_HABS_BIT = 2;
    localparam int FLAG_REV_BIT  = 3;

    // Stream payload widths
    localparam int S_TDATA_BITS = 40;
    localparam int S_TUSER_BITS = 4;
    localparam int M_TDATA_BITS = 48;
    localparam int M_TUSER_BITS = 4;

    // Result queue geometry
    localparam int RESULT_DEPTH = 4;
    localparam int PTR_BITS     = 2;
    localparam int COUNT_BITS   = 3;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] operand;
        logic [15:0] keyword_handle;
        logic [7:0]  keyword_length;
        logic        final_op;
    } op_t;

    typedef struct packed {
        feature_t           feature_type;
        logic signed [16:0] feature_value;
        logic               has_keyword;
        logic [15:0]        keyword_handle;
        logic [7:0]         keyword_length;
        logic               is_last;
    } result_t;

    // Zero, one or two features produced by one operation, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage
`default_nettype wire

// File: rtl/core/mof_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mof_fold: operation register and fold logic
// Registers one operation, merges it into the held move tuple and produces
// up to two features per operation for the result queue.
// ----------------------------------------------------------------------------
module mof_fold #(
    parameter int VALUE_BITS = 18
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire mof_pkg::op_t   in_op,
    input  wire logic           room,
    output mof_pkg::push_t      push
);

    localparam int SUM_BITS = ((VALUE_BITS > 17) ? VALUE_BITS : 17) + 1;
    localparam logic signed [SUM_BITS-1:0] HELD_MAX =
        SUM_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] HELD_MIN =
        SUM_BITS'(-(64'sd1 <<< (VALUE_BITS - 1)));
    localparam logic signed [SUM_BITS-1:0] FEAT_MAX = SUM_BITS'(64'sd65535);
    localparam logic signed [SUM_BITS-1:0] FEAT_MIN = SUM_BITS'(-64'sd65536);

    logic                                  stage_valid_reg;
    mof_pkg::op_t                          stage_reg;
    logic                                  holding_reg;
    logic                                  holding_next;
    logic [mof_pkg::FLAG_BITS-1:0]         held_flags_reg;
    logic [mof_pkg::FLAG_BITS-1:0]         held_flags_next;
    logic signed [VALUE_BITS-1:0]          held_value_reg;
    logic signed [VALUE_BITS-1:0]          held_value_next;
    logic                                  step_fire;

    logic                                  is_valid;
    logic [mof_pkg::FLAG_BITS-1:0]         new_flags;
    logic signed [16:0]                    opnd;
    logic signed [16:0]                    cand_value;
    logic signed [SUM_BITS-1:0]            sum;
    logic signed [VALUE_BITS-1:0]          add_value;
    logic signed [VALUE_BITS-1:0]          rep_value;
    logic                                  merge_add;
    logic                                  merge_rep;
    logic                                  first_valid;
    logic                                  second_valid;
    mof_pkg::result_t                      first;
    mof_pkg::result_t                      second;

    // Saturate a widened value to the held range
    function automatic logic signed [VALUE_BITS-1:0] sat_held(
        input logic signed [SUM_BITS-1:0] s
    );
        logic signed [SUM_BITS-1:0] c;
        begin
            if (s > HELD_MAX)
                c = HELD_MAX;
            else if (s < HELD_MIN)
                c = HELD_MIN;
            else
                c = s;
            return c[VALUE_BITS-1:0];
        end
    endfunction

    // Build a feature from a held tuple
    function automatic mof_pkg::result_t make_feature(
        input logic [mof_pkg::FLAG_BITS-1:0] flags,
        input logic signed [VALUE_BITS-1:0]  value,
        input logic                          kw,
        input logic [15:0]                   handle,
        input logic [7:0]                    length,
        input logic                          last
    );
        mof_pkg::result_t           r;
        logic signed [SUM_BITS-1:0] wide;
        logic signed [SUM_BITS-1:0] clipped;
        begin
            wide = SUM_BITS'(value);
            if (wide > FEAT_MAX)
                clipped = FEAT_MAX;
            else if (wide < FEAT_MIN)
                clipped = FEAT_MIN;
            else
                clipped = wide;
            if (flags[mof_pkg::FLAG_FIND_BIT])
                r.feature_type = flags[mof_pkg::FLAG_REV_BIT] ? mof_pkg::FT_FIND_REV
                                                              : mof_pkg::FT_FIND_FWD;
            else if (flags[mof_pkg::FLAG_HABS_BIT])
                r.feature_type = mof_pkg::FT_ABS_HEAD;
            else if (flags[mof_pkg::FLAG_END_BIT])
                r.feature_type = mof_pkg::FT_ABS_END;
            else
                r.feature_type = value[VALUE_BITS-1] ? mof_pkg::FT_REL_BACK
                                                     : mof_pkg::FT_REL_FWD;
            r.feature_value  = clipped[16:0];
            r.has_keyword    = kw;
            r.keyword_handle = kw ? handle : 16'd0;
            r.keyword_length = kw ? length : 8'd0;
            r.is_last        = last;
            return r;
        end
    endfunction

    // Step when the queue can take two features
    assign step_fire = stage_valid_reg && room;
    assign in_ready  = !stage_valid_reg || room;

    // Hold the incoming operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_reg <= in_op;
        end
    end

    // Decode the operation into a candidate tuple
    always_comb
    begin
        is_valid   = (stage_reg.mode <= mof_pkg::MODE_MATCH);
        opnd       = {1'b0, stage_reg.operand};
        new_flags  = '0;
        cand_value = '0;
        case (stage_reg.mode)
            mof_pkg::MODE_CAPLEN, mof_pkg::MODE_JFWD:
            begin
                cand_value = opnd;
            end
            mof_pkg::MODE_CAPCHR, mof_pkg::MODE_FFWD:
            begin
                new_flags[mof_pkg::FLAG_FIND_BIT] = 1'b1;
                cand_value = opnd;
            end
            mof_pkg::MODE_FREV:
            begin
                new_flags[mof_pkg::FLAG_FIND_BIT] = 1'b1;
                new_flags[mof_pkg::FLAG_REV_BIT]  = 1'b1;
                cand_value = opnd;
            end
            mof_pkg::MODE_CAPEND:
            begin
                new_flags[mof_pkg::FLAG_END_BIT] = 1'b1;
            end
            mof_pkg::MODE_JBACK:
            begin
                cand_value = -opnd;
            end
            mof_pkg::MODE_JABS:
            begin
                new_flags[mof_pkg::FLAG_HABS_BIT] = 1'b1;
                cand_value = opnd;
            end
            mof_pkg::MODE_JEND:
            begin
                new_flags[mof_pkg::FLAG_END_BIT] = 1'b1;
                cand_value = -opnd;
            end
            default:
            begin
                cand_value = '0;
            end
        endcase
        sum       = SUM_BITS'(held_value_reg) + SUM_BITS'(cand_value);
        add_value = sat_held(sum);
        rep_value = sat_held(SUM_BITS'(cand_value));
    end

    // Decide whether the operation folds into the held tuple
    always_comb
    begin
        merge_add = 1'b0;
        merge_rep = 1'b0;
        if (held_flags_reg[mof_pkg::FLAG_FIND_BIT])
        begin
            merge_add = 1'b0;
        end
        else if (held_flags_reg[mof_pkg::FLAG_END_BIT])
        begin
            merge_add = (stage_reg.mode == mof_pkg::MODE_JBACK);
            merge_rep = (stage_reg.mode == mof_pkg::MODE_CAPEND) ||
                        (stage_reg.mode == mof_pkg::MODE_JEND);
        end
        else
        begin
            merge_add = (stage_reg.mode == mof_pkg::MODE_CAPLEN) ||
                        (stage_reg.mode == mof_pkg::MODE_JFWD) ||
                        (stage_reg.mode == mof_pkg::MODE_JBACK);
            merge_rep = (stage_reg.mode == mof_pkg::MODE_JABS);
        end
    end

    // Update the tuple and produce features
    always_comb
    begin
        holding_next    = holding_reg;
        held_flags_next = held_flags_reg;
        held_value_next = held_value_reg;
        first_valid     = 1'b0;
        second_valid    = 1'b0;
        first           = make_feature(held_flags_reg, held_value_reg, 1'b0,
                                       16'd0, 8'd0, 1'b0);
        second          = first;
        if (stage_reg.mode == mof_pkg::MODE_MATCH)
        begin
            first_valid     = 1'b1;
            first           = make_feature(held_flags_reg, held_value_reg, 1'b1,
                                           stage_reg.keyword_handle,
                                           stage_reg.keyword_length,
                                           stage_reg.final_op);
            holding_next    = 1'b0;
            held_flags_next = '0;
            held_value_next = '0;
        end
        else
        begin
            if (is_valid)
            begin
                if (!holding_reg)
                begin
                    holding_next    = 1'b1;
                    held_flags_next = new_flags;
                    held_value_next = rep_value;
                end
                else if (merge_add)
                begin
                    held_value_next = add_value;
                end
                else if (merge_rep)
                begin
                    held_value_next = rep_value;
                    held_flags_next = held_flags_reg | new_flags;
                end
                else
                begin
                    first_valid     = 1'b1;
                    held_flags_next = new_flags;
                    held_value_next = rep_value;
                end
            end
            if (stage_reg.final_op)
            begin
                second_valid    = holding_next;
                second          = make_feature(held_flags_next, held_value_next, 1'b0,
                                               16'd0, 8'd0, 1'b1);
                holding_next    = 1'b0;
                held_flags_next = '0;
                held_value_next = '0;
            end
        end
    end

    // Pack the features in emission order
    always_comb
    begin
        push.count  = step_fire ? ({1'b0, first_valid} + {1'b0, second_valid}) : 2'd0;
        push.first  = first_valid ? first : second;
        push.second = second;
    end

    // Advance the held tuple
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg    <= 1'b0;
            held_flags_reg <= '0;
            held_value_reg <= '0;
        end
        else if (step_fire)
        begin
            holding_reg    <= holding_next;
            held_flags_reg <= held_flags_next;
            held_value_reg <= held_value_next;
        end
    end

    // Idle means an all-zero tuple
    assert property (@(posedge clk) disable iff (!rst_n)
        !holding_reg |-> (held_flags_reg == '0) && (held_value_reg == '0))
        else $error("idle with nonzero held tuple");

    // A final operation leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && stage_reg.final_op |=> !holding_reg)
        else $error("tuple still held after final operation");

    // A keyword operation yields exactly one feature
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && (stage_reg.mode == mof_pkg::MODE_MATCH) |-> push.count == 2'd1)
        else $error("keyword operation feature count wrong");

    // Reverse only appears on find tuples
    assert property (@(posedge clk) disable iff (!rst_n)
        held_flags_reg[mof_pkg::FLAG_REV_BIT] |-> held_flags_reg[mof_pkg::FLAG_FIND_BIT])
        else $error("reverse flag without find flag");

endmodule
`default_nettype wire

// File: rtl/core/mof_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mof_result_fifo: result queue
// Four-entry queue that takes up to two features per cycle and presents one
// feature per cycle to the output stream while out_ready is high.
// ----------------------------------------------------------------------------
module mof_result_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mof_pkg::push_t   push,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mof_pkg::result_t      out_result
);

    mof_pkg::result_t                   mem [mof_pkg::RESULT_DEPTH];
    logic [mof_pkg::PTR_BITS-1:0]       wr_ptr_reg;
    logic [mof_pkg::PTR_BITS-1:0]       rd_ptr_reg;
    logic [mof_pkg::COUNT_BITS-1:0]     count_reg;
    logic [mof_pkg::COUNT_BITS-1:0]     count_next;
    logic                               pop;

    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_result = mem[rd_ptr_reg];
    assign room       = (count_reg <= mof_pkg::COUNT_BITS'(mof_pkg::RESULT_DEPTH - 2));
    assign count_next = count_reg + mof_pkg::COUNT_BITS'(push.count)
                      - mof_pkg::COUNT_BITS'(pop);

    // Write incoming features
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + mof_pkg::PTR_BITS'(push.count);
            rd_ptr_reg <= rd_ptr_reg + mof_pkg::PTR_BITS'(pop);
            count_reg  <= count_next;
        end
    end

    // Pushes only arrive when two entries are free
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |->
            count_reg <= mof_pkg::COUNT_BITS'(mof_pkg::RESULT_DEPTH - 2))
        else $error("push into a queue without room");

    // Fill level never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mof_pkg::COUNT_BITS'(mof_pkg::RESULT_DEPTH))
        else $error("queue fill level out of range");

    // A lone pop drops the fill level by one
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && (push.count == 2'd0) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue fill level not decremented");

endmodule
`default_nettype wire

// File: rtl/core/move_op_folder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// move_op_folder: pattern move-operation folder
// Folds runs of constant moves into one held tuple and emits a feature on a
// keyword, on an operation that cannot be merged, and at the final operation.
//
//   Channel   Direction  Payload
//   s_*       in         operation: tuser = mode, tdata = operand/keyword,
//                        tlast = final_op
//   m_*       out        feature: tuser = type/has_keyword, tdata = value/
//                        keyword, tlast = is_last
//
// One operation per cycle is accepted while the queue has room; an operation
// passes the operation register, then the result queue. It can yield two
// features, and the single-output queue then sets the rate: the four-entry
// queue must have two free entries before the next operation is folded. Reset
// clears the held tuple, the operation register and the queue. Output stalls
// back up through the queue into s_tready.
// ----------------------------------------------------------------------------
module move_op_folder #(
    parameter int VALUE_BITS = 18
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [15:0] operand, [31:16] keyword_handle, [39:32] keyword_length
    input  wire logic [mof_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // [3:0] mode
    input  wire logic [mof_pkg::S_TUSER_BITS-1:0]   s_tuser,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [16:0] feature_value, [32:17] out_keyword_handle,
    // [40:33] out_keyword_length, [47:41] zero
    output logic [mof_pkg::M_TDATA_BITS-1:0]        m_tdata,
    // [2:0] feature_type, [3] has_keyword
    output logic [mof_pkg::M_TUSER_BITS-1:0]        m_tuser,
    output logic                                    m_tlast
);

    mof_pkg::op_t     in_op;
    mof_pkg::push_t   push;
    mof_pkg::result_t out_result;
    logic             room;

    // Unpack the operation transaction
    always_comb
    begin
        in_op.mode           = mof_pkg::mode_t'(s_tuser);
        in_op.operand        = s_tdata[15:0];
        in_op.keyword_handle = s_tdata[31:16];
        in_op.keyword_length = s_tdata[39:32];
        in_op.final_op       = s_tlast;
    end

    mof_fold #(
        .VALUE_BITS (VALUE_BITS)
    ) u_fold (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (in_op),
        .room     (room),
        .push     (push)
    );

    mof_result_fifo u_result_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // Pack the feature transaction
    assign m_tdata = {7'd0, out_result.keyword_length, out_result.keyword_handle,
                      out_result.feature_value};
    assign m_tuser = {out_result.has_keyword, out_result.feature_type};
    assign m_tlast = out_result.is_last;

endmodule
`default_nettype wire
